// ----- src/pps_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the pure pursuit
// steering block. No dependencies.
package pps_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int SC_W   = 34;   // sin/cos CORDIC x, y and z width
    localparam int AT_W   = 50;   // atan CORDIC x, y width
    localparam int AZ_W   = 34;   // atan CORDIC angle width
    localparam int DIV_W  = 31;   // quotient bits below saturation
    localparam int L2_W   = 48;   // lookahead squared
    localparam int NUM_W  = 58;   // 2 * wheelbase * |offset|
    localparam int MAG_W  = 37;   // |lateral offset|, Q21.16

    localparam logic [23:0] LA_RESET = 24'd327680;
    localparam logic [19:0] WB_RESET = 20'd176947;
    localparam logic [SC_W-1:0] SC_X0 = SC_W'(652032874);

    typedef enum logic {
        CFG_LOOKAHEAD = 1'b0,
        CFG_WHEELBASE = 1'b1
    } t_cfg_idx;

    // offsets carried alongside the heading CORDIC
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic               flip;
    } t_sc_tag;

    // sign and special-case flags carried through divider and atan
    typedef struct packed {
        logic neg;
        logic zero;
        logic sat;
    } t_side;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic [31:0] f_atan(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- src/pps_sincos.sv -----
// Pipelined rotation-mode CORDIC: cos and sin of the folded heading, Q2.30.
// Uses pps_pkg; one stage per iteration, carries the position offsets.
module pps_sincos #(
    parameter int STEPS = pps_pkg::CORDIC_STEPS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [pps_pkg::SC_W-1:0]   i_z,
    input  pps_pkg::t_sc_tag                  i_tag,
    output logic                              o_valid,
    output logic signed [pps_pkg::SC_W-1:0]   o_x,
    output logic signed [pps_pkg::SC_W-1:0]   o_y,
    output pps_pkg::t_sc_tag                  o_tag
);
    localparam int W = pps_pkg::SC_W;

    logic                r_v   [STEPS];
    logic signed [W-1:0] r_x   [STEPS];
    logic signed [W-1:0] r_y   [STEPS];
    logic signed [W-1:0] r_z   [STEPS];
    pps_pkg::t_sc_tag    r_tag [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic                v_in;
        logic signed [W-1:0] x_in, y_in, z_in;
        logic signed [W-1:0] n_x, n_y, n_z;
        pps_pkg::t_sc_tag    tag_in;
        logic signed [W-1:0] ang;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign x_in   = pps_pkg::SC_X0;
            assign y_in   = '0;
            assign z_in   = i_z;
            assign tag_in = i_tag;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign x_in   = r_x[k-1];
            assign y_in   = r_y[k-1];
            assign z_in   = r_z[k-1];
            assign tag_in = r_tag[k-1];
        end

        assign ang = W'(pps_pkg::f_atan(5'(k)));

        always_comb begin
            if (z_in >= 0) begin
                n_x = x_in - (y_in >>> k);
                n_y = y_in + (x_in >>> k);
                n_z = z_in - ang;
            end else begin
                n_x = x_in + (y_in >>> k);
                n_y = y_in - (x_in >>> k);
                n_z = z_in + ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]   <= n_x;
                r_y[k]   <= n_y;
                r_z[k]   <= n_z;
                r_tag[k] <= tag_in;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_x     = r_x[STEPS-1];
    assign o_y     = r_y[STEPS-1];
    assign o_tag   = r_tag[STEPS-1];
endmodule

// ----- src/pps_div.sv -----
// Pipelined restoring divider: floor(num * 2^16 / L^2), one quotient bit a stage.
// Uses pps_pkg; user keeps divisor (registered L^2) stable while busy; unchecked.
module pps_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [pps_pkg::NUM_W-1:0]        i_num,
    input  logic [pps_pkg::L2_W-1:0]         i_den,
    input  pps_pkg::t_side                   i_side,
    output logic                             o_valid,
    output logic [pps_pkg::DIV_W-1:0]        o_quo,
    output pps_pkg::t_side                   o_side
);
    localparam int N  = pps_pkg::DIV_W;
    localparam int RW = pps_pkg::L2_W;
    localparam int NW = pps_pkg::NUM_W;

    logic          r_v    [N];
    logic [RW-1:0] r_rem  [N];
    logic [N-1:0]  r_low  [N];
    logic [N-1:0]  r_quo  [N];
    pps_pkg::t_side r_side [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic           v_in;
        logic [RW-1:0]  rem_in;
        logic [N-1:0]   low_in, quo_in;
        pps_pkg::t_side side_in;
        logic [RW:0]    trial;
        logic [RW-1:0]  n_rem;
        logic           qbit;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = RW'(i_num[NW-1:15]);
            assign low_in  = {i_num[14:0], 16'b0};
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            trial = {rem_in, low_in[N-1]};
            qbit  = (trial >= {1'b0, i_den});
            n_rem = qbit ? RW'(trial - {1'b0, i_den}) : trial[RW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_low[k]  <= {low_in[N-2:0], 1'b0};
                r_quo[k]  <= {quo_in[N-2:0], qbit};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[N-1];
    assign o_quo   = r_quo[N-1];
    assign o_side  = r_side[N-1];
endmodule

// ----- src/pps_atan.sv -----
// Pipelined vectoring-mode CORDIC: atan of a nonnegative Q16.16 argument.
// Uses pps_pkg; angle out in 2^32 units per turn, flags carried along.
module pps_atan #(
    parameter int STEPS = pps_pkg::CORDIC_STEPS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [31:0]                      i_arg,
    input  pps_pkg::t_side                   i_side,
    output logic                             o_valid,
    output logic signed [pps_pkg::AZ_W-1:0]  o_z,
    output pps_pkg::t_side                   o_side
);
    localparam int W  = pps_pkg::AT_W;
    localparam int ZW = pps_pkg::AZ_W;

    logic                 r_v    [STEPS];
    logic signed [W-1:0]  r_x    [STEPS];
    logic signed [W-1:0]  r_y    [STEPS];
    logic signed [ZW-1:0] r_z    [STEPS];
    pps_pkg::t_side       r_side [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        logic                 v_in;
        logic signed [W-1:0]  x_in, y_in, n_x, n_y;
        logic signed [ZW-1:0] z_in, n_z, ang;
        pps_pkg::t_side       side_in;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign x_in    = W'(64'h1_0000_0000);
            assign y_in    = W'({i_arg, 16'b0});
            assign z_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign x_in    = r_x[k-1];
            assign y_in    = r_y[k-1];
            assign z_in    = r_z[k-1];
            assign side_in = r_side[k-1];
        end

        assign ang = ZW'(pps_pkg::f_atan(5'(k)));

        always_comb begin
            if (y_in > 0) begin
                n_x = x_in + (y_in >>> k);
                n_y = y_in - (x_in >>> k);
                n_z = z_in + ang;
            end else begin
                n_x = x_in - (y_in >>> k);
                n_y = y_in + (x_in >>> k);
                n_z = z_in - ang;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k]    <= n_x;
                r_y[k]    <= n_y;
                r_z[k]    <= n_z;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_z     = r_z[STEPS-1];
    assign o_side  = r_side[STEPS-1];
endmodule

// ----- src/pure_pursuit_steering_angle.sv -----
// Pure pursuit steering angle, fully pipelined.
// Input channel: i_valid / o_stall with car pose and goal point; an item is
// taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_steer_angle (32768 units = pi).
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 = lookahead distance, 1 = wheelbase); write only while no item is in
// flight.
// Throughput: one item per cycle while the receiver does not stall. Most
// of the pipeline depth is the heading CORDIC, the 31-stage quotient
// pipeline and the atan CORDIC, one register per iteration or bit.
// Reset clears all valid bits and restores the register defaults
// (5.0 m lookahead, 2.7 m wheelbase). When the receiver stalls with a result
// waiting, the whole pipeline holds and o_stall rises; nothing is lost.
// Uses pps_pkg, pps_sincos, pps_div and pps_atan.
module pure_pursuit_steering_angle #(
    parameter int CORDIC_STEPS = pps_pkg::CORDIC_STEPS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_car_x,
    input  logic signed [31:0] i_car_y,
    input  logic [15:0]        i_car_heading,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_steer_angle,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [23:0]        i_cfg_data
);
    localparam int SW = pps_pkg::SC_W;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // configuration
    logic [23:0]              r_la;
    logic [19:0]              r_wb;
    logic [pps_pkg::L2_W-1:0] r_l2;
    logic [23:0]              la_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la <= pps_pkg::LA_RESET;
            r_wb <= pps_pkg::WB_RESET;
        end else if (i_cfg_we) begin
            case (pps_pkg::t_cfg_idx'(i_cfg_idx))
                pps_pkg::CFG_LOOKAHEAD: r_la <= i_cfg_data;
                pps_pkg::CFG_WHEELBASE: r_wb <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    assign la_eff = (r_la == '0) ? 24'd1 : r_la;

    always_ff @(posedge i_clk) begin
        r_l2 <= pps_pkg::L2_W'(la_eff) * pps_pkg::L2_W'(la_eff);
    end

    // stage 0: offsets and heading fold
    logic                 r0_v;
    logic signed [SW-1:0] r0_z;
    pps_pkg::t_sc_tag     r0_tag;
    logic [31:0]          ang_full, ang_fold;
    logic                 flip;

    assign ang_full = {i_car_heading, 16'b0};
    assign flip     = (i_car_heading[15:14] == 2'd1) || (i_car_heading[15:14] == 2'd2);
    assign ang_fold = flip ? (ang_full - 32'h8000_0000) : ang_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_z        <= SW'($signed(ang_fold));
            r0_tag.dx   <= 33'(i_target_x) - 33'(i_car_x);
            r0_tag.dy   <= 33'(i_target_y) - 33'(i_car_y);
            r0_tag.flip <= flip;
        end
    end

    logic                 sc_v;
    logic signed [SW-1:0] sc_x, sc_y;
    pps_pkg::t_sc_tag     sc_tag;

    pps_sincos #(.STEPS(CORDIC_STEPS)) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_v),
        .i_z     (r0_z),
        .i_tag   (r0_tag),
        .o_valid (sc_v),
        .o_x     (sc_x),
        .o_y     (sc_y),
        .o_tag   (sc_tag)
    );

    // stage M: rotate offset into car frame
    logic signed [SW-1:0] cs_c, cs_s;
    logic                 rm_v;
    logic signed [66:0]   rm_p1, rm_p2;

    assign cs_c = sc_tag.flip ? -sc_x : sc_x;
    assign cs_s = sc_tag.flip ? -sc_y : sc_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_v <= 1'b0;
        end else if (en) begin
            rm_v <= sc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rm_p1 <= 67'(sc_tag.dy) * 67'(cs_c);
            rm_p2 <= 67'(sc_tag.dx) * 67'(cs_s);
        end
    end

    // stage D: lateral offset, sign and magnitude
    logic signed [53:0]          diff;
    logic signed [37:0]          dr;
    logic                        rd_v, rd_neg;
    logic [pps_pkg::MAG_W-1:0]   rd_mag;

    assign diff = 54'(rm_p1 >>> 14) - 54'(rm_p2 >>> 14);
    assign dr   = 38'(diff >>> 16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_v <= 1'b0;
        end else if (en) begin
            rd_v <= rm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rd_neg <= dr[37];
            rd_mag <= pps_pkg::MAG_W'(dr[37] ? -dr : dr);
        end
    end

    // stage W: numerator 2 * wb * |dr|
    logic                      rw_v, rw_neg;
    logic [pps_pkg::NUM_W-1:0] rw_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rw_v <= 1'b0;
        end else if (en) begin
            rw_v <= rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rw_neg <= rd_neg;
            rw_num <= (pps_pkg::NUM_W'(rd_mag) * pps_pkg::NUM_W'(r_wb)) << 1;
        end
    end

    // stage S: zero test and saturation test against L^2 * 2^15
    logic                      rs_v;
    logic [pps_pkg::NUM_W-1:0] rs_num;
    pps_pkg::t_side            rs_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rs_v <= 1'b0;
        end else if (en) begin
            rs_v <= rw_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rs_num       <= rw_num;
            rs_side.neg  <= rw_neg;
            rs_side.zero <= (rw_num == '0);
            rs_side.sat  <= (63'(rw_num) >= (63'(r_l2) << 15));
        end
    end

    logic                      dv_v;
    logic [pps_pkg::DIV_W-1:0] dv_quo;
    pps_pkg::t_side            dv_side;
    logic [31:0]               arg;

    pps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rs_v),
        .i_num   (rs_num),
        .i_den   (r_l2),
        .i_side  (rs_side),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    assign arg = dv_side.sat ? 32'h8000_0000 : {1'b0, dv_quo};

    logic                             at_v;
    logic signed [pps_pkg::AZ_W-1:0]  at_z;
    pps_pkg::t_side                   at_side;

    pps_atan #(.STEPS(CORDIC_STEPS)) u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_v),
        .i_arg   (arg),
        .i_side  (dv_side),
        .o_valid (at_v),
        .o_z     (at_z),
        .o_side  (at_side)
    );

    // output: round to 16 bit units, clamp, apply sign
    logic signed [pps_pkg::AZ_W:0] z_rnd;
    logic signed [18:0]            st_raw;
    logic signed [15:0]            st_mag, n_st;
    logic                          r_out_v;
    logic signed [15:0]            r_out_st;

    always_comb begin
        z_rnd  = (pps_pkg::AZ_W+1)'(at_z) + 35'sd32768;
        st_raw = 19'(z_rnd >>> 16);
        if (st_raw < 0) begin
            st_mag = '0;
        end else if (st_raw > 19'sd16384) begin
            st_mag = 16'sd16384;
        end else begin
            st_mag = 16'(st_raw);
        end
        if (at_side.zero) begin
            n_st = '0;
        end else if (at_side.neg) begin
            n_st = -st_mag;
        end else begin
            n_st = st_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= at_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_st <= n_st;
        end
    end

    assign o_valid       = r_out_v;
    assign o_steer_angle = r_out_st;

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_steer_angle <= 16'sd16384) && (o_steer_angle >= -16'sd16384))
        else $error("steering angle out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_steer_angle))
        else $error("stalled result not held");
    a_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && dv_v |-> (r_l2 != '0))
        else $error("zero divisor in flight");
`endif
endmodule

// ----- tb/sv/pps_steer_checker.sv -----
// Watches the item and result channels of the pure pursuit steering block,
// predicts each steering angle and compares. Depends on pps_pkg.
module pps_steer_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_car_x,
    input  logic signed [31:0] i_car_y,
    input  logic [15:0]        i_car_heading,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_steer_angle,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_sat_seen,
    output int                 o_zero_seen
);
    import pps_pkg::*;

    logic [23:0] lookahead;
    logic [19:0] wheelbase;
    logic signed [15:0] angle_q[$];

    // heading to cos/sin in Q2.30
    task automatic heading_sincos(input logic [15:0] h, output longint c, output longint s);
        logic [31:0] a;
        logic        flip;
        longint      x, y, z, nx;
        a = {h, 16'h0};
        flip = (h[15:14] == 2'd1) || (h[15:14] == 2'd2);
        if (flip)
            a = a - 32'h8000_0000;
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - longint'(f_atan(5'(i)));
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + longint'(f_atan(5'(i)));
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint atan_turns(input longint yv);
        longint x, y, z, nx;
        x = longint'(1) << 32;
        y = yv;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + longint'(f_atan(5'(i)));
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - longint'(f_atan(5'(i)));
            end
            x = nx;
        end
        return z;
    endfunction

    task automatic predict_steer(output logic signed [15:0] angle);
        longint dx, dy, c, s, dr, z, st;
        longint unsigned mag, num, len, len2, arg, q, r;
        logic neg;
        dx = longint'(i_target_x) - longint'(i_car_x);
        dy = longint'(i_target_y) - longint'(i_car_y);
        heading_sincos(i_car_heading, c, s);
        dr = (((dy * c) >>> 14) - ((dx * s) >>> 14)) >>> 16;
        neg = dr < 0;
        mag = neg ? longint'(-dr) : dr;
        num = 2 * longint'(wheelbase) * mag;
        len = (lookahead == 0) ? 1 : longint'(lookahead);
        len2 = len * len;
        if (num == 0) begin
            st = 0;
            o_zero_seen++;
        end else begin
            if (num >= (len2 << 15)) begin
                arg = longint'(1) << 31;
                o_sat_seen++;
            end else begin
                q = num / len2;
                r = num % len2;
                arg = (q << 16) + (r << 16) / len2;
            end
            z = atan_turns(longint'(arg << 16));
            st = (z + 32768) >>> 16;
            if (st < 0) st = 0;
            if (st > 16384) st = 16384;
            if (neg) st = -st;
        end
        angle = st[15:0];
    endtask

    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (!i_rst_n) begin
            lookahead <= LA_RESET;
            wheelbase <= WB_RESET;
            angle_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (angle_q.size() == 0) begin
                    $display("%0t: steering angle %0d with no item outstanding",
                             $time, i_steer_angle);
                    o_errors++;
                end else begin
                    want = angle_q.pop_front();
                    if (want !== i_steer_angle) begin
                        $display("%0t: steer_angle expected %0d actual %0d",
                                 $time, want, i_steer_angle);
                        o_errors++;
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                predict_steer(want);
                angle_q.push_back(want);
            end
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_LOOKAHEAD)
                    lookahead <= i_cfg_data;
                else
                    wheelbase <= i_cfg_data[19:0];
            end
            o_pending <= angle_q.size();
        end
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_sat_seen = 0;
        o_zero_seen = 0;
    end
endmodule

// ----- tb/sv/tb_pure_pursuit_steering_angle.sv -----
// Stimulus and verdict for pure_pursuit_steering_angle; checking lives in
// pps_steer_checker. Depends on pps_pkg and the block's RTL.
module tb_pure_pursuit_steering_angle;
    import pps_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_car_x, i_car_y, i_target_x, i_target_y;
    logic [15:0]        i_car_heading;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_steer_angle;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [23:0]        i_cfg_data;

    int  errors, pending, sat_seen, zero_seen;
    int  items_sent;
    bit  quiet;
    bit  hold_req;

    pure_pursuit_steering_angle dut (.*);

    pps_steer_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall),
        .i_car_x, .i_car_y, .i_car_heading, .i_target_x, .i_target_y,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_steer_angle(o_steer_angle),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending),
        .o_sat_seen(sat_seen), .o_zero_seen(zero_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 600000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                for (int k = 0; k < 300; k++) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 14);
                i_stall <= 1'b1;
                for (int k = 0; k < n; k++) @(negedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                // calm stretch
                for (int k = 0; k < $urandom_range(20, 60); k++) @(negedge i_clk);
            end
        end
    end

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_pose(input logic signed [31:0] cx, cy, input logic [15:0] hd,
                             input logic signed [31:0] tx, ty);
        int gap;
        if (!quiet && $urandom_range(0, 11) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 1'b0;
            for (int k = 0; k < gap; k++) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_car_x <= cx;
        i_car_y <= cy;
        i_car_heading <= hd;
        i_target_x <= tx;
        i_target_y <= ty;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        for (int k = 0; k < 80; k++) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // mostly offsets of under 128 m around a random car, some full range
    task automatic random_items(input int count);
        logic signed [31:0] cx, cy, ox, oy;
        for (int k = 0; k < count; k++) begin
            cx = $urandom;
            cy = $urandom;
            if ($urandom_range(0, 4) == 0) begin
                send_pose(cx, cy, 16'($urandom), $urandom, $urandom);
            end else begin
                ox = $signed($urandom) >>> $urandom_range(8, 31);
                oy = $signed($urandom) >>> $urandom_range(8, 31);
                send_pose(cx, cy, 16'($urandom), cx + ox, cy + oy);
            end
        end
    endtask

    task automatic directed_items;
        logic [15:0] hd[8] = '{16'd0, 16'd16383, 16'd16384, 16'd32768,
                               16'd49152, 16'd49151, 16'd65535, 16'd8192};
        foreach (hd[k])
            send_pose(32'sd0, 32'sd0, hd[k], 32'sd196608, 32'sd131072);
        send_pose(32'sd1000, -32'sd1000, 16'd4000, 32'sd1000, -32'sd1000);   // no offset
        send_pose(32'h7fff_ffff, 32'h7fff_ffff, 16'd0, 32'h8000_0000, 32'h8000_0000);
        send_pose(32'h8000_0000, 32'h8000_0000, 16'd16384, 32'h7fff_ffff, 32'h7fff_ffff);
        send_pose(32'h8000_0000, 32'h7fff_ffff, 16'd32768, 32'h7fff_ffff, 32'h8000_0000);
        send_pose(32'sd0, 32'sd0, 16'd0, 32'sd65536, 32'h7fff_ffff);   // saturates
        send_pose(32'sd0, 32'sd0, 16'd0, 32'sd65536, 32'h8000_0000);
        send_pose(32'sd0, 32'sd0, 16'd0, 32'sd327680, 32'sd1);         // tiny lateral
        send_pose(32'sd0, 32'sd0, 16'd0, 32'sd327680, -32'sd1);
        send_pose(32'sd0, 32'sd0, 16'd0, 32'sd0, 32'sd65536);
        send_pose(32'sd0, 32'sd0, 16'd16384, 32'sd65536, 32'sd0);
        send_pose(32'sd0, 32'sd0, 16'd49152, 32'sd65536, 32'sd0);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_car_x = '0;
        i_car_y = '0;
        i_car_heading = '0;
        i_target_x = '0;
        i_target_y = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_LOOKAHEAD;
        i_cfg_data = '0;
        items_sent = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults
        directed_items();
        random_items(200);
        hold_req = 1'b1;
        random_items(200);
        drain();

        // shortest lookahead, longest wheelbase
        write_reg(CFG_LOOKAHEAD, 24'd1);
        write_reg(CFG_WHEELBASE, 24'h0f_ffff);
        directed_items();
        random_items(150);
        drain();

        // longest lookahead, shortest wheelbase
        write_reg(CFG_LOOKAHEAD, 24'hff_ffff);
        write_reg(CFG_WHEELBASE, 24'd1);
        random_items(200);
        drain();

        // zero lookahead acts as one LSB; upper data bits dropped on wheelbase
        write_reg(CFG_LOOKAHEAD, 24'd0);
        write_reg(CFG_WHEELBASE, 24'(24'hf0_0000 | $urandom_range(1, 24'h0f_ffff)));
        random_items(150);
        drain();

        // zero wheelbase forces a straight wheel
        write_reg(CFG_WHEELBASE, 24'd0);
        write_reg(CFG_LOOKAHEAD, 24'd65536);
        random_items(100);
        drain();

        for (int p = 0; p < 3; p++) begin
            write_reg(CFG_LOOKAHEAD,
                      24'($urandom_range(1, 24'hff_ffff) >> $urandom_range(0, 16)));
            write_reg(CFG_WHEELBASE,
                      24'($urandom_range(1, 24'h0f_ffff) >> $urandom_range(0, 12)));
            random_items(120);
            drain();
        end

        // back to defaults, no idling on either side
        write_reg(CFG_LOOKAHEAD, LA_RESET);
        write_reg(CFG_WHEELBASE, 24'(WB_RESET));
        quiet = 1'b1;
        random_items(150);
        drain();

        $display("Sent %0d poses over nine register settings, including a long output hold.",
                 items_sent);
        $display("Saturated arguments: %0d, zero arguments: %0d.", sat_seen, zero_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
